// ===== rtl/atgw_pkg.sv =====
// Shared constants, codes and types of the aligned tile grid walker.
package atgw_pkg;

   localparam int DEF_ALIGN_BYTES    = 64;
   localparam int DEF_COORD_BITS     = 16;

   localparam int REQ_COORD_W        = 16;
   localparam int TILE_POS_W         = 17;
   localparam int TILE_SIZE_W        = 16;
   localparam int PIX_BYTES_W        = 7;

   localparam int CSR_INDEX_W        = 2;
   localparam int CSR_DATA_W         = 16;

   localparam int QUEUE_DEPTH        = 2;
   localparam int DIV_BITS_PER_CYCLE = 4;

   localparam logic [TILE_SIZE_W-1:0] RESET_TILE_W_REQ  = TILE_SIZE_W'(256);
   localparam logic [TILE_SIZE_W-1:0] RESET_TILE_H_REQ  = TILE_SIZE_W'(256);
   localparam logic [PIX_BYTES_W-1:0] RESET_PIX_BYTES   = PIX_BYTES_W'(4);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TILE_W    = 2'd0,
      CSR_TILE_H    = 2'd1,
      CSR_PIX_BYTES = 2'd2
   } csr_index_type;

   typedef enum logic {
      MODE_START = 1'b0,
      MODE_NEXT  = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_STEP,
      BK_WIDTH,
      BK_ORIGIN
   } back_state_type;

   typedef struct packed {
      logic [TILE_SIZE_W-1:0] tile_w_req;
      logic [TILE_SIZE_W-1:0] tile_h_req;
      logic [PIX_BYTES_W-1:0] pix_bytes;
   } csr_type;

endpackage

// ===== rtl/atgw_if.sv =====
// Handshake channels for request and tile beats.
interface atgw_req_if import atgw_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   mode;
   logic [REQ_COORD_W-1:0] region_x;
   logic [REQ_COORD_W-1:0] region_y;
   logic [REQ_COORD_W-1:0] region_w;
   logic [REQ_COORD_W-1:0] region_h;

   modport source (output valid, mode, region_x, region_y, region_w, region_h,
                   input ready);
   modport sink   (input valid, mode, region_x, region_y, region_w, region_h,
                   output ready);
endinterface

interface atgw_rsp_if import atgw_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [TILE_POS_W-1:0]  tile_x;
   logic [TILE_POS_W-1:0]  tile_y;
   logic [TILE_SIZE_W-1:0] tile_w;
   logic [TILE_SIZE_W-1:0] tile_h;
   logic                   last_tile;

   modport source (output valid, tile_x, tile_y, tile_w, tile_h, last_tile,
                   input ready);
   modport sink   (input valid, tile_x, tile_y, tile_w, tile_h, last_tile,
                   output ready);
endinterface

// ===== rtl/atgw_div.sv =====
// Iterative restoring divider, DIV_BITS_PER_CYCLE quotient bits per cycle.
module atgw_div import atgw_pkg::*; #(
   parameter int DW = 17,
   parameter int VW = 9
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient,
   output logic [VW-1:0] remainder
);

   localparam int K     = DIV_BITS_PER_CYCLE;
   localparam int STEPS = (DW + K - 1) / K;
   localparam int PADW  = STEPS * K;
   localparam int CW    = $clog2(STEPS + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [PADW-1:0] num_ff, num_in;
   logic [VW-1:0]   rem_ff, rem_in;
   logic [VW-1:0]   dvs_ff, dvs_in;

   logic [PADW-1:0] num_t;
   logic [VW-1:0]   rem_t;
   logic [VW:0]     rem_w;

   always_comb begin
      num_t = num_ff;
      rem_t = rem_ff;
      rem_w = '0;
      for (int i = 0; i < K; i++) begin
         rem_w = {rem_t, num_t[PADW-1]};
         num_t = {num_t[PADW-2:0], 1'b0};
         if (rem_w >= {1'b0, dvs_ff}) begin
            rem_w    = rem_w - {1'b0, dvs_ff};
            num_t[0] = 1'b1;
         end
         rem_t = rem_w[VW-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(STEPS);
         num_in  = PADW'(dividend);
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         num_in = num_t;
         rem_in = rem_t;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = num_ff[DW-1:0];
   assign remainder = rem_ff;

endmodule

// ===== rtl/atgw_fifo.sv =====
// Small register queue between the front and back parts.
module atgw_fifo import atgw_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != CNTW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNTW'(push) - CNTW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== rtl/atgw_front.sv =====
// Front part: accepts request beats, classifies them and precomputes region edges.
module atgw_front import atgw_pkg::*; #(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int CMD_W      = 8
) (
   atgw_req_if.sink         req,
   input  csr_type          csr,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output logic [CMD_W-1:0] cmd_data
);

   localparam int PW = COORD_BITS + 1;
   localparam int TW = (COORD_BITS > TILE_SIZE_W) ? COORD_BITS : TILE_SIZE_W;
   localparam int NW = ((PW > TW) ? PW : TW) + 1;

   typedef struct packed {
      logic                   is_start;
      logic                   empty;
      logic [PW-1:0]          org_x;
      logic [PW-1:0]          org_y;
      logic [PW-1:0]          end_x;
      logic [PW-1:0]          end_y;
      logic [PW-1:0]          row_bot;
      logic [TW-1:0]          tw;
      logic [TW-1:0]          th;
      logic [PIX_BYTES_W-1:0] pix_bytes;
   } cmd_type;

   logic [COORD_BITS-1:0] rx, ry, rw, rh;
   logic [NW-1:0]         bot_raw;
   cmd_type               cmd;

   assign rx = COORD_BITS'(req.region_x);
   assign ry = COORD_BITS'(req.region_y);
   assign rw = COORD_BITS'(req.region_w);
   assign rh = COORD_BITS'(req.region_h);

   always_comb begin
      cmd.is_start  = (req.mode == MODE_START);
      cmd.empty     = (rw == '0) || (rh == '0);
      cmd.org_x     = PW'(rx);
      cmd.org_y     = PW'(ry);
      cmd.end_x     = PW'(rx) + PW'(rw);
      cmd.end_y     = PW'(ry) + PW'(rh);
      cmd.tw        = (csr.tile_w_req != '0) ? TW'(csr.tile_w_req) : TW'(rw);
      cmd.th        = (csr.tile_h_req != '0) ? TW'(csr.tile_h_req) : TW'(rh);
      cmd.pix_bytes = csr.pix_bytes;
      bot_raw       = NW'(ry) + NW'(cmd.th);
      cmd.row_bot   = (bot_raw >= NW'(cmd.end_y)) ? cmd.end_y : PW'(bot_raw);
   end

   assign cmd_valid = req.valid;
   assign req.ready = cmd_ready;
   assign cmd_data  = CMD_W'(cmd);

endmodule

// ===== rtl/atgw_back.sv =====
// Back part: loads regions through the divider and walks tiles into the output register.
module atgw_back import atgw_pkg::*; #(
   parameter int ALIGN_BYTES = DEF_ALIGN_BYTES,
   parameter int COORD_BITS  = DEF_COORD_BITS,
   parameter int CMD_W       = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  logic [CMD_W-1:0] cmd_data,
   atgw_rsp_if.source       rsp
);

   localparam int PW = COORD_BITS + 1;
   localparam int TW = (COORD_BITS > TILE_SIZE_W) ? COORD_BITS : TILE_SIZE_W;
   localparam int DW = (PW > TW) ? PW : TW;
   localparam int NW = DW + 1;
   localparam int SW = $clog2(ALIGN_BYTES + 1);
   localparam int VW = (SW > PIX_BYTES_W) ? SW : PIX_BYTES_W;

   typedef struct packed {
      logic                   is_start;
      logic                   empty;
      logic [PW-1:0]          org_x;
      logic [PW-1:0]          org_y;
      logic [PW-1:0]          end_x;
      logic [PW-1:0]          end_y;
      logic [PW-1:0]          row_bot;
      logic [TW-1:0]          tw;
      logic [TW-1:0]          th;
      logic [PIX_BYTES_W-1:0] pix_bytes;
   } cmd_type;

   cmd_type        cmd;
   back_state_type state_ff, state_in;

   logic           active_ff, active_in;
   logic           first_col_ff, first_col_in;
   logic           tw_ge_ff, tw_ge_in;
   logic [PW-1:0]  cur_x_ff, cur_x_in;
   logic [PW-1:0]  cur_y_ff, cur_y_in;
   logic [PW-1:0]  row_bot_ff, row_bot_in;
   logic [PW-1:0]  org_x_ff, org_x_in;
   logic [PW-1:0]  end_x_ff, end_x_in;
   logic [PW-1:0]  end_y_ff, end_y_in;
   logic [TW-1:0]  tw_ff, tw_in;
   logic [TW-1:0]  th_ff, th_in;
   logic [SW-1:0]  step_ff, step_in;
   logic [SW-1:0]  rem_ff, rem_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [TILE_POS_W-1:0]  tile_x_ff, tile_x_in;
   logic [TILE_POS_W-1:0]  tile_y_ff, tile_y_in;
   logic [TILE_SIZE_W-1:0] tile_w_ff, tile_w_in;
   logic [TILE_SIZE_W-1:0] tile_h_ff, tile_h_in;
   logic                   last_ff, last_in;

   logic          div_start;
   logic [DW-1:0] div_dividend;
   logic [VW-1:0] div_divisor;
   logic          div_done;
   logic [DW-1:0] div_quotient;
   logic [VW-1:0] div_remainder;

   logic          out_free;
   logic [SW-1:0] adj;
   logic [NW-1:0] nx_raw;
   logic          at_end;
   logic [PW-1:0] nx;
   logic          last_row;
   logic [NW-1:0] bot_raw;
   logic [PW-1:0] next_bot;
   logic [SW-1:0] step_v;

   assign cmd = cmd_type'(cmd_data);

   atgw_div #(
      .DW (DW),
      .VW (VW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   always_comb begin
      out_free = !rsp_valid_ff || rsp.ready;
      adj      = first_col_ff ? rem_ff : '0;
      nx_raw   = NW'(cur_x_ff) + NW'(tw_ff) - NW'(adj);
      at_end   = (nx_raw >= NW'(end_x_ff));
      nx       = at_end ? end_x_ff : PW'(nx_raw);
      last_row = (row_bot_ff >= end_y_ff);
      bot_raw  = NW'(row_bot_ff) + NW'(th_ff);
      next_bot = (bot_raw >= NW'(end_y_ff)) ? end_y_ff : PW'(bot_raw);
      step_v   = (div_quotient == '0) ? SW'(1) : SW'(div_quotient);
   end

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      first_col_in = first_col_ff;
      tw_ge_in     = tw_ge_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      row_bot_in   = row_bot_ff;
      org_x_in     = org_x_ff;
      end_x_in     = end_x_ff;
      end_y_in     = end_y_ff;
      tw_in        = tw_ff;
      th_in        = th_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      tile_x_in    = tile_x_ff;
      tile_y_in    = tile_y_ff;
      tile_w_in    = tile_w_ff;
      tile_h_in    = tile_h_ff;
      last_in      = last_ff;
      cmd_ready    = 1'b0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               if (cmd.is_start) begin
                  cmd_ready = 1'b1;
                  active_in = 1'b0;
                  if (!cmd.empty) begin
                     org_x_in     = cmd.org_x;
                     cur_x_in     = cmd.org_x;
                     cur_y_in     = cmd.org_y;
                     end_x_in     = cmd.end_x;
                     end_y_in     = cmd.end_y;
                     row_bot_in   = cmd.row_bot;
                     tw_in        = cmd.tw;
                     th_in        = cmd.th;
                     first_col_in = 1'b1;
                     div_start    = 1'b1;
                     if (cmd.pix_bytes == '0) begin
                        step_in      = SW'(1);
                        div_dividend = DW'(cmd.tw);
                        div_divisor  = VW'(1);
                        state_in     = BK_WIDTH;
                     end else begin
                        div_dividend = DW'(ALIGN_BYTES);
                        div_divisor  = VW'(cmd.pix_bytes);
                        state_in     = BK_STEP;
                     end
                  end
               end else if (!active_ff) begin
                  cmd_ready = 1'b1;
               end else if (out_free) begin
                  cmd_ready    = 1'b1;
                  rsp_valid_in = 1'b1;
                  tile_x_in    = TILE_POS_W'(cur_x_ff);
                  tile_y_in    = TILE_POS_W'(cur_y_ff);
                  tile_w_in    = TILE_SIZE_W'(nx - cur_x_ff);
                  tile_h_in    = TILE_SIZE_W'(row_bot_ff - cur_y_ff);
                  last_in      = at_end && last_row;
                  if (at_end) begin
                     cur_y_in = row_bot_ff;
                     if (last_row) begin
                        active_in = 1'b0;
                     end else begin
                        cur_x_in     = org_x_ff;
                        row_bot_in   = next_bot;
                        first_col_in = 1'b1;
                     end
                  end else begin
                     cur_x_in     = nx;
                     first_col_in = 1'b0;
                  end
               end
            end
         end
         BK_STEP: begin
            if (div_done) begin
               step_in      = step_v;
               div_start    = 1'b1;
               div_dividend = DW'(tw_ff);
               div_divisor  = VW'(step_v);
               state_in     = BK_WIDTH;
            end
         end
         BK_WIDTH: begin
            if (div_done) begin
               tw_ge_in = (DW'(tw_ff) >= DW'(step_ff));
               if (tw_ge_in) begin
                  tw_in = tw_ff - TW'(div_remainder);
               end
               div_start    = 1'b1;
               div_dividend = DW'(org_x_ff);
               div_divisor  = VW'(step_ff);
               state_in     = BK_ORIGIN;
            end
         end
         BK_ORIGIN: begin
            if (div_done) begin
               rem_in    = tw_ge_ff ? SW'(div_remainder) : '0;
               active_in = 1'b1;
               state_in  = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         active_ff    <= 1'b0;
         first_col_ff <= 1'b0;
         tw_ge_ff     <= 1'b0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         row_bot_ff   <= '0;
         org_x_ff     <= '0;
         end_x_ff     <= '0;
         end_y_ff     <= '0;
         tw_ff        <= TW'(1);
         th_ff        <= TW'(1);
         step_ff      <= SW'(1);
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         first_col_ff <= first_col_in;
         tw_ge_ff     <= tw_ge_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         row_bot_ff   <= row_bot_in;
         org_x_ff     <= org_x_in;
         end_x_ff     <= end_x_in;
         end_y_ff     <= end_y_in;
         tw_ff        <= tw_in;
         th_ff        <= th_in;
         step_ff      <= step_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tile_x_ff <= tile_x_in;
      tile_y_ff <= tile_y_in;
      tile_w_ff <= tile_w_in;
      tile_h_ff <= tile_h_in;
      last_ff   <= last_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.tile_x    = tile_x_ff;
   assign rsp.tile_y    = tile_y_ff;
   assign rsp.tile_w    = tile_w_ff;
   assign rsp.tile_h    = tile_h_ff;
   assign rsp.last_tile = last_ff;

endmodule

// ===== rtl/aligned_tile_grid_walker.sv =====
// Top level of the aligned tile grid walker: settings registers, front, queue and back.
//
//   channel   dir   beat contents                                   accepted when
//   req_chan  in    mode, region_x, region_y, region_w, region_h    valid && ready
//   rsp_chan  out   tile_x, tile_y, tile_w, tile_h, last_tile       valid && ready
//   csr_*     in    csr_index, csr_wdata                            csr_we
//
// While a region is loaded, a next beat's tile is registered as it leaves the queue and
// appears in the cycle after, so tiles stream at one per cycle while the sink keeps taking them.
// A start beat with a non-empty region holds the back part for 3 divisions (2 when
// pixel_bytes is 0) in the 4-bit-per-cycle divider.
// The queue keeps taking beats while the back part divides or the output stalls,
// until its two entries fill.
// Reset is synchronous; no region is loaded after reset.
module aligned_tile_grid_walker import atgw_pkg::*; #(
   parameter int ALIGN_BYTES = DEF_ALIGN_BYTES,
   parameter int COORD_BITS  = DEF_COORD_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   atgw_req_if.sink               req_chan,
   atgw_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PW    = COORD_BITS + 1;
   localparam int TW    = (COORD_BITS > TILE_SIZE_W) ? COORD_BITS : TILE_SIZE_W;
   localparam int CMD_W = 2 + 5 * PW + 2 * TW + PIX_BYTES_W;

   csr_type            csr_ff, csr_in;
   logic               fr_valid;
   logic               fr_ready;
   logic [CMD_W-1:0]   fr_data;
   logic               bk_valid;
   logic               bk_ready;
   logic [CMD_W-1:0]   bk_data;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TILE_W:    csr_in.tile_w_req = TILE_SIZE_W'(csr_wdata);
            CSR_TILE_H:    csr_in.tile_h_req = TILE_SIZE_W'(csr_wdata);
            CSR_PIX_BYTES: csr_in.pix_bytes  = PIX_BYTES_W'(csr_wdata);
            default: begin
               csr_in = csr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.tile_w_req <= RESET_TILE_W_REQ;
         csr_ff.tile_h_req <= RESET_TILE_H_REQ;
         csr_ff.pix_bytes  <= RESET_PIX_BYTES;
      end else begin
         csr_ff <= csr_in;
      end
   end

   atgw_front #(
      .COORD_BITS (COORD_BITS),
      .CMD_W      (CMD_W)
   ) u_front (
      .req       (req_chan),
      .csr       (csr_ff),
      .cmd_valid (fr_valid),
      .cmd_ready (fr_ready),
      .cmd_data  (fr_data)
   );

   atgw_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_data   (fr_data),
      .out_valid (bk_valid),
      .out_ready (bk_ready),
      .out_data  (bk_data)
   );

   atgw_back #(
      .ALIGN_BYTES (ALIGN_BYTES),
      .COORD_BITS  (COORD_BITS),
      .CMD_W       (CMD_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (bk_valid),
      .cmd_ready (bk_ready),
      .cmd_data  (bk_data),
      .rsp       (rsp_chan)
   );

endmodule
